### hdl/lta_pkg.sv
// Package for the link table with aging: command and status codes, field widths
// and parameter defaults shared by the table and its checker.
// No dependencies.
`timescale 1ns / 1ps

package lta_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int TIME_BITS_DEF     = 32;

   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int LIFETIME_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 16'd30;

   // Register index, taken from the word address bit of paddr.
   localparam logic REG_LIFETIME = 1'b0;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_TICK      = 3'd5;

endpackage

### hdl/link_table_with_aging.sv
// Link table with aging: a table of unordered address pairs with expiry times,
// scanned one entry per cycle through a table memory with one write port and one read port.
// Depends on lta_pkg.
`timescale 1ns / 1ps

// How the block is used
// A transaction on the command channel is taken at a rising edge where start is
// high and busy is low. req_cmd selects add/refresh, remove or tick; the two
// addresses name the link and are ignored on a tick.
// Every transaction produces exactly one result, shown for a single cycle with
// rsp_valid high. The receiver cannot stall; it must take the result then.
// Add, remove and tick walk the whole table: one memory read per cycle, the
// entry compared in the next cycle against the link (or its expiry checked
// against the current time by one shared subtract). The walk is followed by a
// finishing state that commits the add and forms the result. busy drops
// together with the result strobe, so a new transaction can be taken only once
// the result of the previous one is shown. The unused command code touches
// nothing and goes straight to the finishing state, without a walk.
// After reset the block clears the valid flags in the table memory, one entry
// per cycle, with busy high until every entry is cleared. The lifetime register can
// be written through the APB-style port at any time the block is idle.
module link_table_with_aging #(
   parameter int TABLE_ENTRIES = lta_pkg::TABLE_ENTRIES_DEF,
   parameter int TIME_BITS     = lta_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [lta_pkg::CMD_W-1:0]         req_cmd,
   input  logic [lta_pkg::ADDR_W-1:0]        req_src_addr,
   input  logic [lta_pkg::ADDR_W-1:0]        req_dst_addr,
   // result channel
   output logic                              rsp_valid,
   output logic [lta_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lta_pkg::COUNT_W-1:0]       rsp_expired_count,
   output logic [lta_pkg::COUNT_W-1:0]       rsp_entry_count,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lta_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lta_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lta_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import lta_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);       // table address
   localparam int IW = $clog2(TABLE_ENTRIES + 1);   // walk counter, holds the depth
   localparam int CW = $clog2(TABLE_ENTRIES + 1);   // entry and expiry counts
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
   localparam logic [IW-1:0] DEPTH    = IW'(TABLE_ENTRIES);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   typedef struct packed {
      logic                   valid;
      logic [ADDR_W-1:0]      src;
      logic [ADDR_W-1:0]      dst;
      logic [TIME_BITS-1:0]   expiry;
   } entry_type;

   // Table memory: one write port, one registered read port.
   entry_type entry_mem_ff [TABLE_ENTRIES];
   entry_type rd_entry_ff;
   logic      wr_en;
   logic [AW-1:0] wr_addr;
   entry_type wr_data;
   logic      rd_en;
   logic [AW-1:0] rd_addr;

   logic [1:0]            state_ff, state_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [AW-1:0]         ev_idx_ff, ev_idx_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     a_ff, a_in;
   logic [ADDR_W-1:0]     b_ff, b_in;
   logic [TIME_BITS-1:0]  exp_ff, exp_in;
   logic                  hit_found_ff, hit_found_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic                  free_found_ff, free_found_in;
   logic [AW-1:0]         free_idx_ff, free_idx_in;
   logic [CW-1:0]         exp_cnt_ff, exp_cnt_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [LIFETIME_W-1:0] lifetime_ff, lifetime_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_expired_ff, rsp_expired_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // Compare of the entry read in the previous cycle.
   logic                  pair_hit;
   logic                  aged;
   logic [TIME_BITS-1:0]  age_diff;

   logic                  csr_write;

   assign pair_hit = rd_entry_ff.valid &&
                     ((rd_entry_ff.src == a_ff && rd_entry_ff.dst == b_ff) ||
                      (rd_entry_ff.src == b_ff && rd_entry_ff.dst == a_ff));
   // Wrap-aware "expiry earlier than now": top bit of the modular difference.
   assign age_diff = rd_entry_ff.expiry - time_ff;
   assign aged     = rd_entry_ff.valid && age_diff[TIME_BITS-1];

   // Configuration port. Only the lifetime register exists.
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_LIFETIME) ? CSR_DATA_W'(lifetime_ff) : '0;

   always_comb begin
      lifetime_in = lifetime_ff;
      if (csr_write && paddr[2] == REG_LIFETIME) begin
         lifetime_in = pwdata[LIFETIME_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rd_pend_in     = 1'b0;
      ev_idx_in      = ev_idx_ff;
      cmd_in         = cmd_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      exp_in         = exp_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      exp_cnt_in     = exp_cnt_ff;
      total_in       = total_ff;
      time_in        = time_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = ev_idx_ff;
      wr_data        = rd_entry_ff;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff[AW-1:0] == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               cmd_in        = req_cmd;
               a_in          = req_src_addr;
               b_in          = req_dst_addr;
               exp_in        = time_ff + TIME_BITS'(lifetime_ff);
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               exp_cnt_in    = '0;
               idx_in        = '0;
               if (req_cmd == CMD_TICK) begin
                  time_in = time_ff + 1'b1;
               end
               if (req_cmd == CMD_ADD || req_cmd == CMD_REMOVE || req_cmd == CMD_TICK) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            // Issue the next read while the previous entry is evaluated.
            if (idx_ff < DEPTH) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               ev_idx_in  = idx_ff[AW-1:0];
               idx_in     = idx_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (pair_hit && !hit_found_ff) begin
                        hit_found_in = 1'b1;
                        hit_idx_in   = ev_idx_ff;
                     end
                     if (!rd_entry_ff.valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = ev_idx_ff;
                     end
                  end
                  CMD_REMOVE: begin
                     if (pair_hit && !hit_found_ff) begin
                        hit_found_in  = 1'b1;
                        hit_idx_in    = ev_idx_ff;
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b0;
                        total_in      = total_ff - 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (aged) begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b0;
                        total_in      = total_ff - 1'b1;
                        exp_cnt_in    = exp_cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (ev_idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            rsp_valid_in   = 1'b1;
            rsp_expired_in = '0;
            state_in       = S_IDLE;
            unique case (cmd_ff)
               CMD_ADD: begin
                  wr_data.valid  = 1'b1;
                  wr_data.src    = a_ff;
                  wr_data.dst    = b_ff;
                  wr_data.expiry = exp_ff;
                  if (hit_found_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = hit_idx_ff;
                     rsp_status_in = STATUS_REFRESHED;
                  end else if (free_found_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = free_idx_ff;
                     total_in      = total_ff + 1'b1;
                     rsp_status_in = STATUS_ADDED;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               CMD_REMOVE: begin
                  rsp_status_in = hit_found_ff ? STATUS_REMOVED : STATUS_NOT_FOUND;
               end
               CMD_TICK: begin
                  rsp_status_in  = STATUS_TICK;
                  rsp_expired_in = COUNT_W'(exp_cnt_ff);
               end
               default: begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            endcase
            rsp_count_in = COUNT_W'(total_in);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         total_ff     <= '0;
         time_ff      <= '0;
         lifetime_ff  <= LIFETIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_pend_ff   <= rd_pend_in;
         total_ff     <= total_in;
         time_ff      <= time_in;
         lifetime_ff  <= lifetime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff      <= ev_idx_in;
      cmd_ff         <= cmd_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      exp_ff         <= exp_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      exp_cnt_ff     <= exp_cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_count = rsp_expired_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

### hdl/lta_checker.sv
// Port-level checker for the link table with aging, and its bind to the top level.
// Depends on lta_pkg and link_table_with_aging.
`timescale 1ns / 1ps

module lta_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [lta_pkg::STATUS_W-1:0]   rsp_status,
   input logic [lta_pkg::COUNT_W-1:0]    rsp_expired_count
);
   import lta_pkg::*;

   // A result follows a busy period; the table is idle again when it shows.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding busy period");

   a_idle_at_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // Only a tick removes entries through aging.
   a_expired_tick_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_TICK) |-> (rsp_expired_count == '0))
      else $error("expired count on a non-tick result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_TICK))
      else $error("undefined status code");

endmodule

bind link_table_with_aging lta_checker u_lta_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_expired_count (rsp_expired_count)
);

### test/lta_tb_pkg.sv
// Scoreboard for the link table testbench: a cycle-free predictor of the table
// and the queue of replies that the block still owes.
// Depends on lta_pkg.
`timescale 1ns / 1ps

package lta_tb_pkg;

   import lta_pkg::*;

   localparam int SLOTS        = TABLE_ENTRIES_DEF;
   localparam int TW           = TIME_BITS_DEF;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  expired_count;
      logic [COUNT_W-1:0]  entry_count;
   } link_reply_type;

   class link_table_scoreboard_type;
      bit                    slot_used   [SLOTS];
      logic [ADDR_W-1:0]     slot_src    [SLOTS];
      logic [ADDR_W-1:0]     slot_dst    [SLOTS];
      logic [TW-1:0]         slot_expiry [SLOTS];
      logic [TW-1:0]         now_ticks;
      logic [COUNT_W-1:0]    live_links;
      logic [LIFETIME_W-1:0] lifetime;
      link_reply_type        replies_due [$];
      int unsigned           failures;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         now_ticks  = '0;
         live_links = '0;
         lifetime   = LIFETIME_RESET;
         failures   = 0;
      endfunction

      function void set_lifetime(logic [CSR_DATA_W-1:0] word);
         lifetime = word[LIFETIME_W-1:0];
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
      endfunction

      // Finds the valid slot that holds the pair in either order.
      function int find_link(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && ((slot_src[i] == a && slot_dst[i] == b) ||
                                 (slot_src[i] == b && slot_dst[i] == a))) return i;
         end
         return -1;
      endfunction

      // Applies one accepted transaction to the table copy and queues its reply.
      function void predict_reply(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] a,
                                  logic [ADDR_W-1:0] b);
         link_reply_type reply;
         logic [TW-1:0]  expiry;
         logic [TW-1:0]  margin;
         int             hit;
         reply.status        = STATUS_NOT_FOUND;
         reply.expired_count = '0;
         expiry              = now_ticks + lifetime;
         case (cmd)
            CMD_ADD: begin
               hit = find_link(a, b);
               if (hit >= 0) begin
                  slot_expiry[hit] = expiry;
                  reply.status     = STATUS_REFRESHED;
               end else begin
                  reply.status = STATUS_FULL;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!slot_used[i]) begin
                        slot_used[i]   = 1'b1;
                        slot_src[i]    = a;
                        slot_dst[i]    = b;
                        slot_expiry[i] = expiry;
                        live_links     = live_links + 1'b1;
                        reply.status   = STATUS_ADDED;
                        break;
                     end
                  end
               end
            end
            CMD_REMOVE: begin
               hit = find_link(a, b);
               if (hit >= 0) begin
                  slot_used[hit] = 1'b0;
                  live_links     = live_links - 1'b1;
                  reply.status   = STATUS_REMOVED;
               end
            end
            CMD_TICK: begin
               now_ticks = now_ticks + 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i]) begin
                     // Wrap-aware: the entry is stale when expiry - now is negative.
                     margin = slot_expiry[i] - now_ticks;
                     if (margin[TW-1]) begin
                        slot_used[i]        = 1'b0;
                        live_links          = live_links - 1'b1;
                        reply.expired_count = reply.expired_count + 1'b1;
                     end
                  end
               end
               reply.status = STATUS_TICK;
            end
            default: ;
         endcase
         reply.entry_count = live_links;
         replies_due = {replies_due, reply};
      endfunction

      function void check_reply(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] expired,
                                logic [COUNT_W-1:0] count);
         link_reply_type due;
         if (replies_due.size() == 0) begin
            flag_failure($sformatf("unexpected result: status %0d expired %0d entries %0d",
                                   status, expired, count));
            return;
         end
         due = replies_due.pop_front();
         if (status !== due.status || expired !== due.expired_count ||
             count !== due.entry_count)
            flag_failure($sformatf({"result mismatch: expected status %0d expired %0d ",
                                    "entries %0d, got status %0d expired %0d entries %0d"},
                                   due.status, due.expired_count, due.entry_count,
                                   status, expired, count));
      endfunction
   endclass

endpackage

### test/tb_top.sv
// Top-level testbench of the link table with aging: drives commands and the
// lifetime register, predicts every reply and checks it when it comes out.
// Depends on lta_pkg, lta_tb_pkg and the link_table_with_aging RTL.
`timescale 1ns / 1ps

module tb_top;

   import lta_pkg::*;
   import lta_tb_pkg::*;

   // The command code that the block has no operation for.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // The lifetime register is word 0; the word beside it is not mapped.
   localparam logic [CSR_ADDR_W-1:0] LIFETIME_ADDR = {REG_LIFETIME, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR    = {~REG_LIFETIME, 2'b00};

   localparam int PHASE_ITEMS    = 150;
   localparam int POOL_SIZE      = 16;
   localparam int TAIL_CYCLES    = TABLE_ENTRIES_DEF + 8;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_W-1:0]      req_cmd;
   logic [ADDR_W-1:0]     req_src_addr;
   logic [ADDR_W-1:0]     req_dst_addr;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_expired_count;
   logic [COUNT_W-1:0]    rsp_entry_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   link_table_scoreboard_type link_model;
   int                        quiet_cycles;

   // A command transaction completes at an edge where start is high and busy low.
   wire command_taken = start && (busy === 1'b0);

   always #4 clock = ~clock;

   link_table_with_aging dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_expired_count(rsp_expired_count),
      .rsp_entry_count  (rsp_entry_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Monitor and watchdog. Everything is sampled at the rising edge, so the
   // values seen are the ones that held during the cycle that just ended. Every
   // accepted command feeds the predictor; every strobed result is checked
   // against the oldest prediction. The watchdog counts edges with neither an
   // accepted command nor a result and gives up when the count gets too large.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (command_taken)
            link_model.predict_reply(req_cmd, req_src_addr, req_dst_addr);
         if (rsp_valid === 1'b1)
            link_model.check_reply(rsp_status, rsp_expired_count, rsp_entry_count);
         if (command_taken || rsp_valid === 1'b1) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offers one command transaction. The sender first idles for a random number
   // of cycles, then holds start until the block takes the transaction. Once it
   // is taken, the request fields are filled with junk that must be ignored.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] src,
                               input logic [ADDR_W-1:0] dst, input int idle_pct);
      @(posedge clock);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_src_addr <= src;
      req_dst_addr <= dst;
      do @(posedge clock); while (busy !== 1'b0);
      start        <= 1'b0;
      req_cmd      <= CMD_W'($urandom_range(0, 3));
      req_src_addr <= $urandom;
      req_dst_addr <= $urandom;
   endtask

   // One APB transfer: a setup cycle, then an access cycle held until pready.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Waits until the block owes nothing and has dropped busy. Right after reset
   // this also covers the clearing pass over the table.
   task automatic drain_replies();
      @(posedge clock);
      while (link_model.replies_due.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Sets a new lifetime while the block is idle. The upper data bits carry
   // junk that the register must drop. A write to the unmapped word follows,
   // and the read back proves that it left the lifetime alone.
   task automatic program_lifetime(input logic [LIFETIME_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] readback;
      drain_replies();
      word = $urandom;
      word[LIFETIME_W-1:0] = value;
      csr_access(1'b1, LIFETIME_ADDR, word, readback);
      link_model.set_lifetime(word);
      csr_access(1'b1, SPARE_ADDR, $urandom, readback);
      csr_access(1'b0, LIFETIME_ADDR, '0, readback);
      if (readback[LIFETIME_W-1:0] !== value)
         link_model.flag_failure($sformatf("lifetime read back: expected %0d, got %0d",
                                           value, readback[LIFETIME_W-1:0]));
   endtask

   // One phase of random traffic. Addresses mostly come from a small pool so
   // that links repeat in both orders, which makes refreshes and removes hit
   // and lets the table fill up. Now and then a stray address is used instead.
   // The command mix is weighted per phase; what is left over after add,
   // remove and tick goes to the unused command code.
   task automatic run_phase(input logic [LIFETIME_W-1:0] lifetime, input int idle_pct,
                            input int add_w, input int remove_w, input int tick_w);
      logic [ADDR_W-1:0] pool [POOL_SIZE];
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      int unsigned       pick;
      program_lifetime(lifetime);
      foreach (pool[i]) pool[i] = $urandom;
      repeat (PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < add_w)                         cmd = CMD_ADD;
         else if (pick < add_w + remove_w)         cmd = CMD_REMOVE;
         else if (pick < add_w + remove_w + tick_w) cmd = CMD_TICK;
         else                                      cmd = CMD_UNUSED;
         a = pool[$urandom_range(0, POOL_SIZE - 1)];
         b = pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 15) == 0) a = $urandom;
         send_command(cmd, a, b, idle_pct);
      end
   endtask

   initial begin
      link_model   = new();
      reset        <= 1'b1;
      start        <= 1'b0;
      req_cmd      <= CMD_ADD;
      req_src_addr <= '0;
      req_dst_addr <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part with a short lifetime so that aging shows up quickly.
      program_lifetime(16'd2);
      send_command(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 0);
      send_command(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_command(CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 0);
      // The same link with its endpoints swapped must refresh, not insert.
      send_command(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 0);
      // A link whose two endpoints are equal is an ordinary link.
      send_command(CMD_ADD, 32'h1234_5678, 32'h1234_5678, 0);
      send_command(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 0);
      send_command(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 0);
      // The unused command code changes nothing and reports not found.
      send_command(CMD_UNUSED, 32'hDEAD_BEEF, 32'h0BAD_F00D, 0);
      // Only one endpoint matches here, so nothing is removed.
      send_command(CMD_REMOVE, 32'h1234_5678, 32'h8765_4321, 0);
      send_command(CMD_ADD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0);
      // Ticks ignore their addresses. By the fourth one everything has aged out.
      repeat (4) send_command(CMD_TICK, $urandom, $urandom, 0);
      send_command(CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 0);
      send_command(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

      // Random part. The first phase is add heavy with few ticks, which fills
      // the table. Lifetime zero expires an entry on the first tick after it.
      // The last phase uses the largest lifetime so that no link added in it ages out.
      run_phase(16'd40,    29, 75,  5, 15);
      run_phase(16'd1,     29, 45, 15, 35);
      run_phase(16'd0,     83, 45, 15, 35);
      run_phase(16'd30,    83, 50, 20, 25);
      run_phase(16'd3,      0, 45, 20, 30);
      run_phase(16'hFFFF,   0, 60, 25, 10);

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (link_model.failures == 0 && link_model.replies_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
